FILE: rtl/core/ucpd_pkg.sv
// ----------------------------------------------------------------------------
// Unicode code point decoder package
// Shared types and constants for the decoder pipeline.
// ----------------------------------------------------------------------------
package ucpd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LeftW     = 24;
  localparam int unsigned CodeW     = 32;
  localparam int unsigned UsedW     = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 2;
  localparam int unsigned Utf8ValW  = 21;
  localparam int unsigned UnitW     = 16;

  localparam logic [CfgIdxW-1:0] RegUnitSize    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegNativeOrder = CfgIdxW'(1);

  localparam logic [5:0] HighSurTag = 6'b110110;
  localparam logic [5:0] LowSurTag  = 6'b110111;
  localparam logic [Utf8ValW-1:0] SupplementaryBase = 21'h10000;

  typedef enum logic [1:0] {
    UNIT_UTF8  = 2'd0,
    UNIT_UTF16 = 2'd1,
    UNIT_UTF32 = 2'd2
  } unit_e;

  typedef struct packed {
    logic [3:0][ByteW-1:0] b;
    logic                  ge1;
    logic                  ge2;
    logic                  ge3;
    logic                  ge4;
    logic                  odd;
    logic                  mis4;
    unit_e                 unit;
    logic                  swap;
  } s1_t;

  typedef struct packed {
    unit_e                 unit;
    logic                  gate;
    logic                  ge2;
    logic                  ge3;
    logic                  ge4;
    logic [2:0]            len8;
    logic [3:1]            cont_ok;
    logic [3:0][ByteW-1:0] b;
    logic [UnitW-1:0]      hi;
    logic [UnitW-1:0]      lo;
    logic [CodeW-1:0]      word;
  } s2_t;

endpackage

FILE: rtl/core/ucpd_if.sv
// ----------------------------------------------------------------------------
// Decoder channel interfaces
// Valid/ready channels for the byte window and for the decoded result.
// ----------------------------------------------------------------------------
interface ucpd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  in_byte_0;
  logic [7:0]  in_byte_1;
  logic [7:0]  in_byte_2;
  logic [7:0]  in_byte_3;
  logic [23:0] bytes_left;

  modport source (output valid, in_byte_0, in_byte_1, in_byte_2, in_byte_3, bytes_left,
                  input ready);
  modport sink   (input valid, in_byte_0, in_byte_1, in_byte_2, in_byte_3, bytes_left,
                  output ready);
endinterface

interface ucpd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_point;
  logic [2:0]  bytes_used;
  logic        decode_ok;

  modport source (output valid, code_point, bytes_used, decode_ok, input ready);
  modport sink   (input valid, code_point, bytes_used, decode_ok, output ready);
endinterface

FILE: rtl/core/unicode_code_point_decoder_core.sv
// ----------------------------------------------------------------------------
// Unicode code point decoder core
// Decodes one UTF-8, UTF-16 or UTF-32 code point from a four-byte window.
//
// The input channel carries the next four text bytes and the count of bytes
// left; the output channel returns the code point, the bytes used and a valid
// flag. The user must set unit size and byte order through the write port
// only while the block is idle; the block itself does not enforce this.
// Each transfer passes three register stages: window capture and masking,
// unit ordering and lead classification, then final decode into the output
// register. A new window is taken every cycle unless a stall fills all three.
// When the receiver stalls, the stages fill up one by one and input ready
// falls only once all three hold an item, so nothing is lost or repeated.
// Reset empties the pipeline and restores UTF-8 with native byte order.
// ----------------------------------------------------------------------------
module unicode_code_point_decoder_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ucpd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ucpd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  ucpd_in_if.sink                        in_ch,
  ucpd_out_if.source                     out_ch
);
  import ucpd_pkg::*;

  unit_e            unit_q;
  logic             native_q;
  logic             v1_q, v2_q, v3_q;
  logic             adv1, adv2, adv3;
  s1_t              s1_d, s1_q;
  s2_t              s2_d, s2_q;
  logic [CodeW-1:0] cp_d, cp_q;
  logic [UsedW-1:0] used_d, used_q;
  logic             ok_d, ok_q;
  logic [LeftW-1:0] left;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q   <= UNIT_UTF8;
      native_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegUnitSize) begin
        unit_q <= unit_e'(cfg_wdata_i);
      end else if (cfg_idx_i == RegNativeOrder) begin
        native_q <= cfg_wdata_i[0];
      end
    end
  end

  assign adv3 = !v3_q || out_ch.ready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_ch.ready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_ch.valid;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign left = in_ch.bytes_left;

  always_comb begin
    s1_d.ge1  = |left;
    s1_d.ge2  = |left[LeftW-1:1];
    s1_d.ge3  = (|left[LeftW-1:2]) || (&left[1:0]);
    s1_d.ge4  = |left[LeftW-1:2];
    s1_d.odd  = left[0];
    s1_d.mis4 = |left[1:0];
    s1_d.unit = unit_q;
    s1_d.swap = !native_q;
    s1_d.b[0] = s1_d.ge1 ? in_ch.in_byte_0 : '0;
    s1_d.b[1] = s1_d.ge2 ? in_ch.in_byte_1 : '0;
    s1_d.b[2] = s1_d.ge3 ? in_ch.in_byte_2 : '0;
    s1_d.b[3] = s1_d.ge4 ? in_ch.in_byte_3 : '0;
  end

  ucpd_unit_stage u_unit_stage (
    .s1_i (s1_q),
    .s2_o (s2_d)
  );

  always_comb begin
    ok_d   = 1'b0;
    cp_d   = '0;
    used_d = '0;
    if (s2_q.gate) begin
      case (s2_q.unit)
        UNIT_UTF8: begin
          case (s2_q.len8)
            3'd1: begin
              ok_d = 1'b1;
              cp_d = CodeW'(s2_q.b[0]);
            end
            3'd2: begin
              ok_d = s2_q.ge2 && s2_q.cont_ok[1];
              cp_d = CodeW'({s2_q.b[0][4:0], s2_q.b[1][5:0]});
            end
            3'd3: begin
              ok_d = s2_q.ge3 && (&s2_q.cont_ok[2:1]);
              cp_d = CodeW'({s2_q.b[0][3:0], s2_q.b[1][5:0], s2_q.b[2][5:0]});
            end
            3'd4: begin
              ok_d = s2_q.ge4 && (&s2_q.cont_ok);
              cp_d = CodeW'({s2_q.b[0][2:0], s2_q.b[1][5:0], s2_q.b[2][5:0],
                             s2_q.b[3][5:0]});
            end
            default: ok_d = 1'b0;
          endcase
          used_d = s2_q.len8;
        end
        UNIT_UTF16: begin
          if (s2_q.hi[15:10] == HighSurTag) begin
            ok_d   = s2_q.ge4 && (s2_q.lo[15:10] == LowSurTag);
            cp_d   = CodeW'(SupplementaryBase + {1'b0, s2_q.hi[9:0], s2_q.lo[9:0]});
            used_d = UsedW'(4);
          end else begin
            ok_d   = 1'b1;
            cp_d   = CodeW'(s2_q.hi);
            used_d = UsedW'(2);
          end
        end
        UNIT_UTF32: begin
          ok_d   = 1'b1;
          cp_d   = s2_q.word;
          used_d = UsedW'(4);
        end
        default: ok_d = 1'b0;
      endcase
    end
    if (!ok_d) begin
      cp_d   = '0;
      used_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_ch.valid) begin
      s1_q <= s1_d;
    end
    if (adv2 && v1_q) begin
      s2_q <= s2_d;
    end
    if (adv3 && v2_q) begin
      cp_q   <= cp_d;
      used_q <= used_d;
      ok_q   <= ok_d;
    end
  end

  assign out_ch.valid      = v3_q;
  assign out_ch.code_point = cp_q;
  assign out_ch.bytes_used = used_q;
  assign out_ch.decode_ok  = ok_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch.ready |-> (v1_q && v2_q && v3_q))
    else $error("Input stalled while a pipeline stage was empty.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !ok_q) |-> (cp_q == '0 && used_q == '0))
    else $error("Rejected result carries a nonzero code point or byte count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && ok_q) |-> (used_q == 3'd1 || used_q == 3'd2 || used_q == 3'd3 ||
                        used_q == 3'd4))
    else $error("Accepted result has an impossible byte count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && ok_q && unit_q == UNIT_UTF32) |-> (used_q == 3'd4))
    else $error("UTF-32 result does not consume a full word.");

endmodule

FILE: rtl/core/ucpd_unit_stage.sv
// ----------------------------------------------------------------------------
// Decoder unit stage
// Orders the window bytes into code units and classifies the UTF-8 lead.
// ----------------------------------------------------------------------------
module ucpd_unit_stage (
  input  ucpd_pkg::s1_t s1_i,
  output ucpd_pkg::s2_t s2_o
);
  import ucpd_pkg::*;

  logic [ByteW-1:0] lead;

  assign lead = s1_i.b[0];

  always_comb begin
    s2_o.unit = s1_i.unit;
    s2_o.ge2  = s1_i.ge2;
    s2_o.ge3  = s1_i.ge3;
    s2_o.ge4  = s1_i.ge4;
    s2_o.b    = s1_i.b;

    case (s1_i.unit)
      UNIT_UTF8:  s2_o.gate = s1_i.ge1;
      UNIT_UTF16: s2_o.gate = s1_i.ge2 && !s1_i.odd;
      UNIT_UTF32: s2_o.gate = s1_i.ge4 && !s1_i.mis4;
      default:    s2_o.gate = 1'b0;
    endcase

    if (!lead[7]) begin
      s2_o.len8 = 3'd1;
    end else if (lead[7:5] == 3'b110) begin
      s2_o.len8 = 3'd2;
    end else if (lead[7:4] == 4'b1110) begin
      s2_o.len8 = 3'd3;
    end else if (lead[7:3] == 5'b11110) begin
      s2_o.len8 = 3'd4;
    end else begin
      s2_o.len8 = 3'd0;
    end

    for (int i = 1; i < 4; i++) begin
      s2_o.cont_ok[i] = (s1_i.b[i][7:6] == 2'b10);
    end

    if (s1_i.swap) begin
      s2_o.hi   = {s1_i.b[0], s1_i.b[1]};
      s2_o.lo   = {s1_i.b[2], s1_i.b[3]};
      s2_o.word = {s1_i.b[0], s1_i.b[1], s1_i.b[2], s1_i.b[3]};
    end else begin
      s2_o.hi   = {s1_i.b[1], s1_i.b[0]};
      s2_o.lo   = {s1_i.b[3], s1_i.b[2]};
      s2_o.word = {s1_i.b[3], s1_i.b[2], s1_i.b[1], s1_i.b[0]};
    end
  end

endmodule
